>>> hdl/ppdq_pkg.sv
package ppdq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int INDEX_BITS  = 20;
    localparam int MAX_RESULTS = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int OCC_W       = PTR_W + 1;
    localparam int DATA_W      = 32;
    localparam int WIN_W       = 5;
    localparam int CNT_W       = 5;
    localparam int CMD_W       = 3;
    localparam int KIND_W      = 2;
    localparam int ADDR_W      = 3;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD        = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DATA_READY = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PAYMENT    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_NEXT_LOAD  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_NEXT_SEND  = 3'd4;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_LENGTH  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UPDATED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SEND    = 2'd3;

    // entry phases
    localparam logic [1:0] PH_NOTREQ  = 2'd0;
    localparam logic [1:0] PH_LOADING = 2'd1;
    localparam logic [1:0] PH_READY   = 2'd2;
    localparam logic [1:0] PH_WAITING = 2'd3;

    // register indexes (byte address bit 2)
    localparam logic REG_LOAD_WINDOW   = 1'b0;
    localparam logic REG_UNPAID_WINDOW = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [CNT_W-1:0]      count;
        logic [INDEX_BITS-1:0] piece;
        logic [DATA_W-1:0]     handle;
        logic                  last;
        logic                  full;
    } t_result;

    typedef struct packed {
        logic accept;  // item taken this cycle
        logic step;    // commit the scanned entry, advance
        logic finish;  // scan over, post any summary result
        logic flush;   // move held result to output as final beat
    } t_dp_cmd;

    typedef struct packed {
        logic done;
        logic can_step;
        logic pend_valid;
        logic out_free;
    } t_dp_stat;

    // entries to scan: window clipped to the occupancy and the result limit
    function automatic logic [OCC_W-1:0] scan_limit(input logic [WIN_W-1:0] win,
                                                    input logic [OCC_W-1:0] occ);
        int n;
        n = int'(win);
        if (n > int'(occ)) begin
            n = int'(occ);
        end
        if (n > MAX_RESULTS) begin
            n = MAX_RESULTS;
        end
        return OCC_W'(n);
    endfunction

endpackage

>>> hdl/paid_piece_delivery_queue.sv
// In-order queue of up to 16 requested pieces, one command per input beat.
// Add waits in the flush state for the output register; payment and unknown
// commands never stall the input. Data ready scans every occupied entry;
// next load and next send scan the front window (clipped to the occupancy)
// one entry per cycle while no held result waits on a stalled output.
// The scan reads entries through the single read port of the entry store.
// Results leave through a one-deep output register and a held result, so a
// batch of n results only stalls the scan when the output side stalls. A
// batch that finds nothing gives no beat; payment never gives one. Windows
// are written over the APB port at 0x0 (load window) and 0x4 (unpaid window),
// 5 bits each, both 4 after reset, and must only be written while the block
// is idle.
module paid_piece_delivery_queue (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [ppdq_pkg::CMD_W-1:0]      i_cmd,
    input  logic [ppdq_pkg::INDEX_BITS-1:0] i_piece_index,
    input  logic [ppdq_pkg::DATA_W-1:0]     i_data_handle,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [ppdq_pkg::KIND_W-1:0]     o_result_kind,
    output logic [ppdq_pkg::CNT_W-1:0]      o_count,
    output logic [ppdq_pkg::INDEX_BITS-1:0] o_piece_index_res,
    output logic [ppdq_pkg::DATA_W-1:0]     o_data_handle_res,
    output logic                            o_last,
    output logic                            o_full_res,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ppdq_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import ppdq_pkg::*;

    logic [WIN_W-1:0] r_load_window;
    logic [WIN_W-1:0] r_unpaid_window;
    logic             cfg_wr;
    t_dp_cmd          ctl;
    t_dp_stat         stat;
    t_result          res;

    // register write on the access phase; pready is tied high
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_window   <= WIN_W'(4);
            r_unpaid_window <= WIN_W'(4);
        end else if (cfg_wr) begin
            if (paddr[2] == REG_LOAD_WINDOW) begin
                r_load_window <= pwdata[WIN_W-1:0];
            end else begin
                r_unpaid_window <= pwdata[WIN_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_UNPAID_WINDOW) ? 32'(r_unpaid_window)
                                                    : 32'(r_load_window);

    ppdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .i_stat     (stat),
        .o_ctl      (ctl),
        .o_in_stall (o_in_stall)
    );

    ppdq_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_stat          (stat),
        .i_cmd           (i_cmd),
        .i_piece_index   (i_piece_index),
        .i_data_handle   (i_data_handle),
        .i_load_window   (r_load_window),
        .i_unpaid_window (r_unpaid_window),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_result        (res)
    );

    // unpack the result beat
    assign o_result_kind     = res.kind;
    assign o_count           = res.count;
    assign o_piece_index_res = res.piece;
    assign o_data_handle_res = res.handle;
    assign o_last            = res.last;
    assign o_full_res        = res.full;

endmodule

>>> hdl/ppdq_ctrl.sv
module ppdq_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [ppdq_pkg::CMD_W-1:0]  i_cmd,
    input  ppdq_pkg::t_dp_stat          i_stat,
    output ppdq_pkg::t_dp_cmd           o_ctl,
    output logic                        o_in_stall
);
    import ppdq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.accept = 1'b1;
                    case (i_cmd)
                        CMD_ADD:        n_state = ST_FLUSH;
                        CMD_DATA_READY: n_state = ST_SCAN;
                        CMD_NEXT_LOAD:  n_state = ST_SCAN;
                        CMD_NEXT_SEND:  n_state = ST_SCAN;
                        default:        n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN: begin
                if (i_stat.done) begin
                    o_ctl.finish = 1'b1;
                    n_state      = ST_FLUSH;
                end else if (i_stat.can_step) begin
                    o_ctl.step = 1'b1;
                end
            end
            ST_FLUSH: begin
                if (!i_stat.pend_valid) begin
                    n_state = ST_IDLE;
                end else if (i_stat.out_free) begin
                    o_ctl.flush = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

>>> hdl/ppdq_dp.sv
module ppdq_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ppdq_pkg::t_dp_cmd              i_ctl,
    output ppdq_pkg::t_dp_stat             o_stat,
    input  logic [ppdq_pkg::CMD_W-1:0]     i_cmd,
    input  logic [ppdq_pkg::INDEX_BITS-1:0] i_piece_index,
    input  logic [ppdq_pkg::DATA_W-1:0]    i_data_handle,
    input  logic [ppdq_pkg::WIN_W-1:0]     i_load_window,
    input  logic [ppdq_pkg::WIN_W-1:0]     i_unpaid_window,
    input  logic                           i_out_stall,
    output logic                           o_out_valid,
    output ppdq_pkg::t_result              o_result
);
    import ppdq_pkg::*;

    // entry store, no reset: only occupied entries are read
    logic [INDEX_BITS-1:0] r_piece [QUEUE_DEPTH];
    logic [1:0]            r_phase [QUEUE_DEPTH];
    logic [DATA_W-1:0]     r_data  [QUEUE_DEPTH];

    logic [PTR_W-1:0]      r_head;
    logic [OCC_W-1:0]      r_occ;
    logic [CMD_W-1:0]      r_cmd;
    logic [INDEX_BITS-1:0] r_piece_in;
    logic [DATA_W-1:0]     r_handle_in;
    logic [OCC_W-1:0]      r_k;
    logic [OCC_W-1:0]      r_limit;
    logic [OCC_W-1:0]      r_cnt;
    logic                  r_pend_valid;
    t_result               r_pend;
    logic                  r_out_valid;
    t_result               r_out;

    logic [PTR_W-1:0]      slot;
    logic [PTR_W-1:0]      tail;
    logic [1:0]            ph;
    logic                  full;
    logic                  hit_dr;
    logic                  hit_ld;
    logic                  hit_sd;
    logic                  stop;
    logic                  emit;
    logic                  out_free;
    logic                  load_out;
    logic [OCC_W-1:0]      limit;
    t_result               emit_res;
    t_result               add_res;
    t_result               upd_res;
    t_result               out_res;

    assign slot     = r_head + r_k[PTR_W-1:0];
    assign tail     = r_head + r_occ[PTR_W-1:0];
    assign ph       = r_phase[slot];
    assign full     = (r_occ == OCC_W'(QUEUE_DEPTH));
    assign hit_dr   = (r_cmd == CMD_DATA_READY) && (ph == PH_LOADING)
                      && (r_piece[slot] == r_piece_in);
    assign hit_ld   = (r_cmd == CMD_NEXT_LOAD) && (ph == PH_NOTREQ);
    assign hit_sd   = (r_cmd == CMD_NEXT_SEND) && (ph == PH_READY);
    assign stop     = (r_cmd == CMD_NEXT_SEND)
                      && ((ph == PH_NOTREQ) || (ph == PH_LOADING));
    assign emit     = hit_ld || hit_sd;
    assign out_free = !r_out_valid || !i_out_stall;
    assign load_out = (i_ctl.step && emit && r_pend_valid) || i_ctl.flush;

    always_comb begin
        case (i_cmd)
            CMD_DATA_READY: limit = r_occ;
            CMD_NEXT_LOAD:  limit = scan_limit(i_load_window, r_occ);
            CMD_NEXT_SEND:  limit = scan_limit(i_unpaid_window, r_occ);
            default:        limit = '0;
        endcase
    end

    always_comb begin
        emit_res        = '0;
        emit_res.kind   = hit_ld ? KIND_LOAD : KIND_SEND;
        emit_res.piece  = hit_ld ? r_piece[slot] : '0;
        emit_res.handle = hit_sd ? r_data[slot] : '0;
    end

    // summary results and the beat moved to the output register
    always_comb begin
        add_res       = '0;
        add_res.kind  = KIND_LENGTH;
        add_res.full  = full;
        add_res.count = full ? CNT_W'(r_occ) : CNT_W'(OCC_W'(r_occ + 1'b1));
        upd_res       = '0;
        upd_res.kind  = KIND_UPDATED;
        upd_res.count = CNT_W'(r_cnt);
        out_res       = r_pend;
        out_res.last  = i_ctl.flush;
    end

    assign o_stat.done       = (r_k == r_limit) || stop;
    assign o_stat.can_step   = !(emit && r_pend_valid && !out_free);
    assign o_stat.pend_valid = r_pend_valid;
    assign o_stat.out_free   = out_free;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_occ        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_ctl.accept) begin
                if (i_cmd == CMD_ADD) begin
                    r_pend_valid <= 1'b1;
                    if (!full) begin
                        r_occ <= r_occ + 1'b1;
                    end
                end
                if ((i_cmd == CMD_PAYMENT) && (r_occ != '0)) begin
                    r_head <= r_head + 1'b1;
                    r_occ  <= r_occ - 1'b1;
                end
            end
            if (i_ctl.step && emit) begin
                r_pend_valid <= 1'b1;
            end
            if (i_ctl.finish && (r_cmd == CMD_DATA_READY)) begin
                r_pend_valid <= 1'b1;
            end
            if (i_ctl.flush) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    // payload and entry store
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cmd       <= i_cmd;
            r_piece_in  <= i_piece_index;
            r_handle_in <= i_data_handle;
            r_k         <= '0;
            r_cnt       <= '0;
            r_limit     <= limit;
            if (i_cmd == CMD_ADD) begin
                r_pend <= add_res;
                if (!full) begin
                    r_piece[tail] <= i_piece_index;
                    r_phase[tail] <= PH_NOTREQ;
                end
            end
        end
        if (i_ctl.step) begin
            r_k <= r_k + 1'b1;
            if (hit_dr) begin
                r_phase[slot] <= PH_READY;
                r_data[slot]  <= r_handle_in;
                r_cnt         <= r_cnt + 1'b1;
            end
            if (emit) begin
                r_phase[slot] <= hit_ld ? PH_LOADING : PH_WAITING;
                r_pend        <= emit_res;
                if (r_pend_valid) begin
                    r_out <= out_res;
                end
            end
        end
        if (i_ctl.finish && (r_cmd == CMD_DATA_READY)) begin
            r_pend <= upd_res;
        end
        if (i_ctl.flush) begin
            r_out <= out_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

>>> sim/delivery_queue_checker.sv
// Watches both beat channels and the APB port, keeps its own copy of the
// queue and the windows, and compares every result beat in order.
module delivery_queue_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic [ppdq_pkg::CMD_W-1:0]      i_cmd,
    input  logic [ppdq_pkg::INDEX_BITS-1:0] i_piece_index,
    input  logic [ppdq_pkg::DATA_W-1:0]     i_data_handle,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  ppdq_pkg::t_result               i_result,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic                            i_pready,
    input  logic [ppdq_pkg::ADDR_W-1:0]     i_paddr,
    input  logic [31:0]                     i_pwdata,
    output int                              o_mismatches,
    output int                              o_pending,
    output int                              o_beats
);
    timeunit 1ns;
    timeprecision 1ps;
    import ppdq_pkg::*;

    logic [INDEX_BITS-1:0] slot_piece [QUEUE_DEPTH];
    logic [1:0]            slot_phase [QUEUE_DEPTH];
    logic [DATA_W-1:0]     slot_data  [QUEUE_DEPTH];
    logic [PTR_W-1:0]      head;
    int                    fill;
    logic [WIN_W-1:0]      load_win;
    logic [WIN_W-1:0]      unpaid_win;
    t_result               due_results [$];
    int                    fault_cnt;
    int                    beat_cnt;

    // window clipped to the queue length and the per-batch result limit
    function automatic int window_span(input logic [WIN_W-1:0] win);
        int n;
        n = int'(win);
        if (n > fill) begin
            n = fill;
        end
        if (n > MAX_RESULTS) begin
            n = MAX_RESULTS;
        end
        return n;
    endfunction

    task automatic apply_command(input logic [CMD_W-1:0]      code,
                                 input logic [INDEX_BITS-1:0] piece,
                                 input logic [DATA_W-1:0]     handle);
        t_result          r;
        int               n;
        int               first;
        logic [PTR_W-1:0] s;
        r     = '0;
        n     = 0;
        first = due_results.size();
        case (code)
            CMD_ADD: begin
                r.kind = KIND_LENGTH;
                r.last = 1'b1;
                if (fill >= QUEUE_DEPTH) begin
                    r.count = CNT_W'(fill);
                    r.full  = 1'b1;
                end else begin
                    s             = head + PTR_W'(fill);
                    slot_piece[s] = piece;
                    slot_phase[s] = PH_NOTREQ;
                    slot_data[s]  = '0;
                    fill++;
                    r.count = CNT_W'(fill);
                end
                due_results.insert(due_results.size(), r);
            end
            CMD_DATA_READY: begin
                for (int k = 0; k < fill; k++) begin
                    s = head + PTR_W'(k);
                    if (slot_piece[s] == piece && slot_phase[s] == PH_LOADING) begin
                        slot_phase[s] = PH_READY;
                        slot_data[s]  = handle;
                        n++;
                    end
                end
                r.kind  = KIND_UPDATED;
                r.count = CNT_W'(n);
                r.last  = 1'b1;
                due_results.insert(due_results.size(), r);
            end
            CMD_PAYMENT: begin
                if (fill != 0) begin
                    head = head + 1'b1;
                    fill--;
                end
            end
            CMD_NEXT_LOAD: begin
                n = window_span(load_win);
                for (int k = 0; k < n; k++) begin
                    s = head + PTR_W'(k);
                    if (slot_phase[s] == PH_NOTREQ) begin
                        slot_phase[s] = PH_LOADING;
                        r       = '0;
                        r.kind  = KIND_LOAD;
                        r.piece = slot_piece[s];
                        due_results.insert(due_results.size(), r);
                    end
                end
            end
            CMD_NEXT_SEND: begin
                n = window_span(unpaid_win);
                for (int k = 0; k < n; k++) begin
                    s = head + PTR_W'(k);
                    if (slot_phase[s] == PH_NOTREQ || slot_phase[s] == PH_LOADING) begin
                        break;
                    end
                    if (slot_phase[s] == PH_READY) begin
                        slot_phase[s] = PH_WAITING;
                        r        = '0;
                        r.kind   = KIND_SEND;
                        r.handle = slot_data[s];
                        due_results.insert(due_results.size(), r);
                    end
                end
            end
            default: ;
        endcase
        // batches flag their final beat
        if ((code == CMD_NEXT_LOAD || code == CMD_NEXT_SEND) && due_results.size() > first) begin
            due_results[due_results.size() - 1].last = 1'b1;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fault_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            head       = '0;
            fill       = 0;
            load_win   = WIN_W'(4);
            unpaid_win = WIN_W'(4);
            due_results.delete();
        end else begin
            // results first, so a beat can never match a command taken at this edge
            if (i_out_valid && !i_out_stall) begin
                beat_cnt++;
                if (due_results.size() == 0) begin
                    $error("unexpected result beat: kind %0d count %0d", i_result.kind,
                           i_result.count);
                    fault_cnt++;
                end else begin
                    want = due_results[0];
                    due_results.delete(0);
                    check_field("result_kind", 32'(want.kind), 32'(i_result.kind));
                    check_field("count", 32'(want.count), 32'(i_result.count));
                    check_field("piece_index_res", 32'(want.piece), 32'(i_result.piece));
                    check_field("data_handle_res", want.handle, i_result.handle);
                    check_field("last", 32'(want.last), 32'(i_result.last));
                    check_field("full_res", 32'(want.full), 32'(i_result.full));
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[2])
                    REG_LOAD_WINDOW:   load_win   = i_pwdata[WIN_W-1:0];
                    REG_UNPAID_WINDOW: unpaid_win = i_pwdata[WIN_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                apply_command(i_cmd, i_piece_index, i_data_handle);
            end
        end
        o_mismatches <= fault_cnt;
        o_beats      <= beat_cnt;
        o_pending    <= due_results.size();
    end

endmodule

>>> sim/tb_paid_piece_delivery_queue.sv
// Stimulus and verdict for the piece delivery queue. Prediction and
// comparison live in delivery_queue_checker; this module only drives.
module tb_paid_piece_delivery_queue;
    timeunit 1ns;
    timeprecision 1ps;
    import ppdq_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int HOLD_CYCLES   = 400;  // long output hold-off under pressure
    localparam int SETTLE_CYCLES = 30;   // idle wait that outlasts any command
    localparam int BURST_ITEMS   = 48;
    localparam int POOL_SIZE     = 6;
    localparam int POOL_W        = $clog2(POOL_SIZE);

    // codes 5 to 7 carry no meaning
    localparam logic [CMD_W-1:0]      CMD_UNUSED_FIRST = 3'd5;
    localparam logic [CMD_W-1:0]      CMD_UNUSED_LAST  = 3'd7;
    localparam logic [INDEX_BITS-1:0] PIECE_MAX        = '1;
    localparam logic [DATA_W-1:0]     HANDLE_MAX       = '1;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_in_valid    = 1'b0;
    logic [CMD_W-1:0]      i_cmd         = '0;
    logic [INDEX_BITS-1:0] i_piece_index = '0;
    logic [DATA_W-1:0]     i_data_handle = '0;
    logic                  i_out_stall   = 1'b0;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [ADDR_W-1:0]     paddr         = '0;
    logic [31:0]           pwdata        = '0;

    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [KIND_W-1:0]     o_result_kind;
    logic [CNT_W-1:0]      o_count;
    logic [INDEX_BITS-1:0] o_piece_index_res;
    logic [DATA_W-1:0]     o_data_handle_res;
    logic                  o_last;
    logic                  o_full_res;
    logic [31:0]           prdata;
    logic                  pready;

    int mismatches;
    int pending;
    int beats_seen;

    int send_idle_pct = 0;  // chance per cycle that the sender holds back
    int stall_pct     = 0;  // chance per cycle that the receiver stalls
    logic hold_req    = 1'b0;
    logic hold_done   = 1'b0;
    int hold_left     = 0;
    int cycle_cnt     = 0;
    int items_sent    = 0;

    // small pool of piece numbers so data ready finds loading entries,
    // often several at once
    logic [INDEX_BITS-1:0] piece_pool [POOL_SIZE];

    always #10 i_clk = ~i_clk;

    paid_piece_delivery_queue dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_cmd             (i_cmd),
        .i_piece_index     (i_piece_index),
        .i_data_handle     (i_data_handle),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_result_kind     (o_result_kind),
        .o_count           (o_count),
        .o_piece_index_res (o_piece_index_res),
        .o_data_handle_res (o_data_handle_res),
        .o_last            (o_last),
        .o_full_res        (o_full_res),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // result fields packed in t_result order
    delivery_queue_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_piece_index (i_piece_index),
        .i_data_handle (i_data_handle),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_result      ({o_result_kind, o_count, o_piece_index_res, o_data_handle_res,
                         o_last, o_full_res}),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_mismatches  (mismatches),
        .o_pending     (pending),
        .o_beats       (beats_seen)
    );

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: random stalls per phase, plus one long hold-off once asked
    // for. The hold is counted here so the sender keeps offering beats and
    // the queue backs up into the input.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            i_out_stall <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            hold_done   <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // One command beat. Valid is only lowered when a gap is taken, so
    // back-to-back beats never see valid dropped and raised in one step.
    task automatic send_beat(input logic [CMD_W-1:0]      code,
                             input logic [INDEX_BITS-1:0] piece,
                             input logic [DATA_W-1:0]     handle);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cmd         <= code;
        i_piece_index <= piece;
        i_data_handle <= handle;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    // Drop valid, wait for every expected beat, then cover commands that
    // give no result but still keep the block busy.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup phase, access phase, then an idle phase so that a
    // following write never lowers and raises psel in one step.
    task automatic write_window(input logic reg_sel, input logic [WIN_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random commands, mostly well-formed traffic on the pool pieces.
    // add_pct steers the fill level: high keeps the queue full, low drains it.
    task automatic random_burst(input int n_items, input int add_pct);
        int                    sel;
        logic [INDEX_BITS-1:0] piece;
        logic [DATA_W-1:0]     handle;
        for (int p = 0; p < POOL_SIZE; p++) begin
            piece_pool[POOL_W'(p)] = INDEX_BITS'($urandom);
        end
        for (int i = 0; i < n_items; i++) begin
            sel    = $urandom_range(99);
            piece  = INDEX_BITS'($urandom);
            handle = $urandom;
            if (sel < add_pct) begin
                if ($urandom_range(99) < 85) begin
                    piece = piece_pool[POOL_W'($urandom_range(POOL_SIZE - 1))];
                end
                send_beat(CMD_ADD, piece, handle);
            end else if (sel < add_pct + 22) begin
                if ($urandom_range(99) < 90) begin
                    piece = piece_pool[POOL_W'($urandom_range(POOL_SIZE - 1))];
                end
                send_beat(CMD_DATA_READY, piece, handle);
            end else if (sel < add_pct + 37) begin
                send_beat(CMD_NEXT_LOAD, piece, handle);
            end else if (sel < add_pct + 52) begin
                send_beat(CMD_NEXT_SEND, piece, handle);
            end else if (sel < 96) begin
                send_beat(CMD_PAYMENT, piece, handle);
            end else begin
                send_beat(CMD_W'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST)),
                          piece, handle);
            end
        end
    endtask

    initial begin
        logic [WIN_W-1:0] load_w;
        logic [WIN_W-1:0] unpaid_w;
        int               add_pct;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: full-width windows so one batch can reach the 16-beat limit.
        write_window(REG_LOAD_WINDOW, WIN_W'(16));
        write_window(REG_UNPAID_WINDOW, WIN_W'(16));
        send_beat(CMD_PAYMENT, PIECE_MAX, HANDLE_MAX);      // pop on empty queue
        send_beat(CMD_UNUSED_FIRST, PIECE_MAX, HANDLE_MAX);
        send_beat(CMD_UNUSED_LAST, '0, '0);
        send_beat(CMD_DATA_READY, PIECE_MAX, HANDLE_MAX);   // nothing loading: count 0
        send_beat(CMD_NEXT_LOAD, '0, '0);                   // empty batch, no beat
        send_beat(CMD_NEXT_SEND, '0, '0);
        // fill to the brim; all-ones index repeats so data ready hits several
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            if (k == 0 || k % 4 == 2) begin
                send_beat(CMD_ADD, PIECE_MAX, $urandom);
            end else if (k == 1) begin
                send_beat(CMD_ADD, '0, $urandom);
            end else begin
                send_beat(CMD_ADD, INDEX_BITS'($urandom), $urandom);
            end
        end
        send_beat(CMD_ADD, INDEX_BITS'($urandom), $urandom);  // refused: queue full
        send_beat(CMD_NEXT_LOAD, '0, '0);                     // sixteen loads
        send_beat(CMD_DATA_READY, PIECE_MAX, HANDLE_MAX);
        send_beat(CMD_NEXT_SEND, '0, '0);                     // head only, stops at next
        send_beat(CMD_PAYMENT, '0, '0);

        // Random phases; each one rewrites both windows while idle.
        for (int ph = 0; ph < 6; ph++) begin
            settle();
            case (ph)
                0: begin
                    load_w = 5'd4;  unpaid_w = 5'd4;  add_pct = 30;
                    send_idle_pct = 0;  stall_pct = 0;
                end
                1: begin
                    load_w = 5'd1;  unpaid_w = 5'd16; add_pct = 30;
                    send_idle_pct = 88; stall_pct = 0;
                end
                2: begin
                    load_w = 5'd16; unpaid_w = 5'd1;  add_pct = 14;
                    send_idle_pct = 0;  stall_pct = 88;
                end
                3: begin
                    // zero scans nothing, 31 is clipped by the length
                    load_w = 5'd0;  unpaid_w = 5'd31; add_pct = 30;
                    send_idle_pct = 11; stall_pct = 11;
                end
                4: begin
                    load_w   = WIN_W'($urandom_range(16, 1));
                    unpaid_w = WIN_W'($urandom_range(16, 1));
                    add_pct  = 30;
                    send_idle_pct = 0;  stall_pct = 0;
                end
                default: begin
                    load_w = 5'd16; unpaid_w = 5'd16; add_pct = 14;
                    send_idle_pct = 11; stall_pct = 11;
                end
            endcase
            write_window(REG_LOAD_WINDOW, load_w);
            write_window(REG_UNPAID_WINDOW, unpaid_w);
            if (ph == 4) begin
                hold_req <= 1'b1;
            end
            random_burst(BURST_ITEMS, add_pct);
        end

        settle();
        $display("Run covered %0d commands over seven window settings, incl. empty and full",
                 items_sent);
        $display("queue, batches up to the result limit and a long output hold-off; %0d beats.",
                 beats_seen);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
